FILE: sv/marching_squares_cell_segments_top_defines.svh
// ---------------------------------------------------------------------------
// Marching squares cell segments: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef MARCHING_SQUARES_CELL_SEGMENTS_TOP_DEFINES_SVH
`define MARCHING_SQUARES_CELL_SEGMENTS_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define MSC_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("same-cycle check failed");
// Next-cycle implication.
`define MSC_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("next-cycle check failed");
`else
`define MSC_ASSERT_IMPL(lbl, pre, post)
`define MSC_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

FILE: sv/msc_pkg.sv
// ---------------------------------------------------------------------------
// Marching squares cell segments: package
// Payload types, command and status structs, state codes and edge tables.
// ---------------------------------------------------------------------------
package msc_pkg;

  localparam int MAX_LEVELS    = 16;
  localparam int MAX_GRID_SIDE = 1024;
  localparam int LVL_CNT_W     = $clog2(MAX_LEVELS + 1);

  // Shared divider geometry.
  localparam int DVD_W = 44;
  localparam int DVS_W = 27;
  localparam int QUO_W = 17;
  localparam int DIV_CNT_W = $clog2(QUO_W);

  typedef enum logic [1:0] {
    REG_LEVEL_INTERVAL = 2'd0,
    REG_TILE_EXTENT    = 2'd1,
    REG_GRID_WIDTH     = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    EDGE_TOP    = 2'd0,
    EDGE_RIGHT  = 2'd1,
    EDGE_BOTTOM = 2'd2,
    EDGE_LEFT   = 2'd3
  } edge_t;

  typedef struct packed {
    logic signed [15:0] corner_tl;
    logic signed [15:0] corner_tr;
    logic signed [15:0] corner_bl;
    logic signed [15:0] corner_br;
    logic [9:0]         cell_col;
    logic [9:0]         cell_row;
  } cell_in_t;

  typedef struct packed {
    logic signed [15:0] level_index;
    logic [15:0]        start_x;
    logic [15:0]        start_y;
    logic [15:0]        end_x;
    logic [15:0]        end_y;
    logic [22:0]        start_slot;
    logic [22:0]        end_slot;
    logic               last_segment;
    logic               levels_dropped;
  } seg_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_KDIV,
    ST_LVL_T,
    ST_LVL_CAP,
    ST_LEVEL,
    ST_MUL1,
    ST_MUL2,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } msc_state_t;

  typedef struct packed {
    logic load_in;
    logic kdiv_start;
    logic kmin_load;
    logic t_init;
    logic cap;
    logic case_latch;
    logic mul1;
    logic mul2;
    logic div_go;
    logic coord_store;
    logic emit;
    logic seg_next;
    logic lvl_next;
  } msc_cmd_t;

  typedef struct packed {
    logic cell_ok;
    logic div_busy;
    logic level_live;
    logic coord_last;
    logic seg_more;
    logic out_free;
  } msc_status_t;

  typedef struct packed {
    edge_t from_edge;
    edge_t to_edge;
  } seg_edges_t;

  // Edges of segment s for a corner case (TL=8, TR=4, BR=2, BL=1).
  function automatic seg_edges_t seg_edges(input logic [3:0] cs, input logic s);
    seg_edges_t r;
    r = '{from_edge: EDGE_TOP, to_edge: EDGE_TOP};
    unique case (cs)
      4'd1:    r = '{from_edge: EDGE_BOTTOM, to_edge: EDGE_LEFT};
      4'd2:    r = '{from_edge: EDGE_RIGHT,  to_edge: EDGE_BOTTOM};
      4'd3:    r = '{from_edge: EDGE_RIGHT,  to_edge: EDGE_LEFT};
      4'd4:    r = '{from_edge: EDGE_TOP,    to_edge: EDGE_RIGHT};
      4'd5:    r = s ? '{from_edge: EDGE_TOP,    to_edge: EDGE_RIGHT}
                     : '{from_edge: EDGE_BOTTOM, to_edge: EDGE_LEFT};
      4'd6:    r = '{from_edge: EDGE_TOP,    to_edge: EDGE_BOTTOM};
      4'd7:    r = '{from_edge: EDGE_TOP,    to_edge: EDGE_LEFT};
      4'd8:    r = '{from_edge: EDGE_LEFT,   to_edge: EDGE_TOP};
      4'd9:    r = '{from_edge: EDGE_BOTTOM, to_edge: EDGE_TOP};
      4'd10:   r = s ? '{from_edge: EDGE_RIGHT, to_edge: EDGE_BOTTOM}
                     : '{from_edge: EDGE_LEFT,  to_edge: EDGE_TOP};
      4'd11:   r = '{from_edge: EDGE_RIGHT,  to_edge: EDGE_TOP};
      4'd12:   r = '{from_edge: EDGE_LEFT,   to_edge: EDGE_RIGHT};
      4'd13:   r = '{from_edge: EDGE_BOTTOM, to_edge: EDGE_RIGHT};
      4'd14:   r = '{from_edge: EDGE_LEFT,   to_edge: EDGE_BOTTOM};
      default: r = '{from_edge: EDGE_TOP,    to_edge: EDGE_TOP};
    endcase
    return r;
  endfunction

  // Half-step offsets of an edge midpoint within the cell.
  function automatic logic [1:0] edge_u(input edge_t e);
    logic [1:0] r;
    unique case (e)
      EDGE_TOP:    r = 2'd1;
      EDGE_RIGHT:  r = 2'd2;
      EDGE_BOTTOM: r = 2'd1;
      default:     r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] edge_v(input edge_t e);
    logic [1:0] r;
    unique case (e)
      EDGE_TOP:    r = 2'd0;
      EDGE_RIGHT:  r = 2'd1;
      EDGE_BOTTOM: r = 2'd2;
      default:     r = 2'd1;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/msc_div.sv
// ---------------------------------------------------------------------------
// Marching squares cell segments: divider
// Restoring divider, one quotient bit per cycle; quotient must fit QUO_W.
// ---------------------------------------------------------------------------
module msc_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [msc_pkg::DVD_W-1:0] dividend,
  input  logic [msc_pkg::DVS_W-1:0] divisor,
  output logic                      busy,
  output logic [msc_pkg::QUO_W-1:0] quotient
);
  import msc_pkg::*;

  logic [DVD_W-1:0]     rem;
  logic [DVD_W-1:0]     dsh;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 fits;

  assign fits = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dsh      <= DVD_W'(divisor) << (QUO_W - 1);
      cnt      <= DIV_CNT_W'(QUO_W - 1);
      quotient <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quotient <= {quotient[QUO_W-2:0], fits};
      dsh      <= dsh >> 1;
      cnt      <= cnt - 1'b1;
    end
  end

endmodule

FILE: sv/msc_datapath.sv
// ---------------------------------------------------------------------------
// Marching squares cell segments: datapath
// Configuration, cell registers, level stepping, endpoint arithmetic and
// the output register.
// ---------------------------------------------------------------------------
`include "marching_squares_cell_segments_top_defines.svh"

module msc_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  msc_pkg::cell_in_t   in_data,
  input  msc_pkg::msc_cmd_t   cmd,
  output msc_pkg::msc_status_t st,
  output logic                out_valid,
  input  logic                out_stall,
  output msc_pkg::seg_out_t   out_data
);
  import msc_pkg::*;

  logic [15:0] lvl_iv;
  logic [15:0] extent;
  logic [10:0] gwidth;

  cell_in_t           cur_cell;
  logic signed [15:0] mn;
  logic signed [15:0] mx;
  logic signed [17:0] k;
  logic signed [23:0] t;
  logic [LVL_CNT_W-1:0] cnt;
  logic               dropped;
  logic [3:0]         case_r;
  logic               seg_sel;
  logic [1:0]         coord_idx;
  logic [15:0]        coord_r [4];
  logic [25:0]        p1;
  logic [25:0]        den;
  logic signed [17:0] n_r;
  logic signed [43:0] num;
  logic [15:0]        pre;
  logic               need;

  // Minimum and maximum of the incoming corners.
  logic signed [15:0] in_mn, in_mx, mn_a, mn_b, mx_a, mx_b;
  always_comb begin
    mn_a  = (in_data.corner_tl < in_data.corner_tr) ? in_data.corner_tl : in_data.corner_tr;
    mn_b  = (in_data.corner_bl < in_data.corner_br) ? in_data.corner_bl : in_data.corner_br;
    mx_a  = (in_data.corner_tl > in_data.corner_tr) ? in_data.corner_tl : in_data.corner_tr;
    mx_b  = (in_data.corner_bl > in_data.corner_br) ? in_data.corner_bl : in_data.corner_br;
    in_mn = (mn_a < mn_b) ? mn_a : mn_b;
    in_mx = (mx_a > mx_b) ? mx_a : mx_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lvl_iv <= 16'd10;
      extent <= 16'd4096;
      gwidth <= 11'd256;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_LEVEL_INTERVAL: lvl_iv <= cfg_data;
        REG_TILE_EXTENT:    extent <= cfg_data;
        REG_GRID_WIDTH:     gwidth <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Level arithmetic.
  logic signed [23:0] iv_s, mx_s, t_next, tcap, cap_step;
  logic signed [34:0] t_prod;
  logic signed [17:0] kdvd_s;
  logic               next_live;
  assign iv_s     = {8'd0, lvl_iv};
  assign mx_s     = 24'(mx);
  assign t_next   = t + iv_s;
  assign cap_step = 24'(lvl_iv * MAX_LEVELS);
  assign tcap     = t + cap_step;
  assign t_prod   = k * $signed({1'b0, lvl_iv});
  assign kdvd_s   = mn[15] ? -18'(mn) : 18'(mn) + 18'(lvl_iv) - 18'sd1;
  assign next_live = (t_next < mx_s) && ((cnt + 1'b1) < LVL_CNT_W'(MAX_LEVELS));

  logic [3:0] case_now;
  assign case_now = {24'(cur_cell.corner_tl) > t, 24'(cur_cell.corner_tr) > t,
                     24'(cur_cell.corner_br) > t, 24'(cur_cell.corner_bl) > t};

  // Endpoint operand selection.
  seg_edges_t         edges;
  edge_t              cur_edge;
  logic               axis_y, interp;
  logic [9:0]         base;
  logic signed [15:0] ca, cb;
  logic signed [16:0] d_raw;
  logic signed [17:0] n_raw, n_norm;
  logic [15:0]        d_mag;
  always_comb begin
    edges    = seg_edges(case_r, seg_sel);
    cur_edge = coord_idx[1] ? edges.to_edge : edges.from_edge;
    axis_y   = coord_idx[0];
    interp   = 1'b0;
    base     = cur_cell.cell_col;
    ca       = cur_cell.corner_tl;
    cb       = cur_cell.corner_tr;
    unique case (cur_edge)
      EDGE_TOP: begin
        if (axis_y) begin
          base = cur_cell.cell_row - 10'd1;
        end else begin
          interp = 1'b1;
        end
      end
      EDGE_RIGHT: begin
        if (axis_y) begin
          base   = cur_cell.cell_row;
          interp = 1'b1;
          ca     = cur_cell.corner_tr;
          cb     = cur_cell.corner_br;
        end
      end
      EDGE_BOTTOM: begin
        if (axis_y) begin
          base = cur_cell.cell_row;
        end else begin
          interp = 1'b1;
          ca     = cur_cell.corner_bl;
          cb     = cur_cell.corner_br;
        end
      end
      default: begin
        if (axis_y) begin
          base   = cur_cell.cell_row;
          interp = 1'b1;
          ca     = cur_cell.corner_tl;
          cb     = cur_cell.corner_bl;
        end else begin
          base = cur_cell.cell_col - 10'd1;
        end
      end
    endcase
    d_raw = 17'(ca) - 17'(cb);
    n_raw = 18'(t - 24'(cb));
    if (!interp || d_raw == '0) begin
      d_mag  = 16'd1;
      n_norm = '0;
    end else if (d_raw < 0) begin
      d_mag  = 16'(-d_raw);
      n_norm = -n_raw;
    end else begin
      d_mag  = 16'(d_raw);
      n_norm = n_raw;
    end
  end

  logic signed [27:0] numr;
  logic signed [44:0] num_prod;
  logic [DVD_W-1:0]   dvd;
  logic [DVS_W-1:0]   dvs;
  logic               nonpos, sat;
  assign numr     = $signed({2'b0, p1}) - 28'(n_r);
  assign num_prod = numr * $signed({1'b0, extent});
  assign dvd      = {num[42:0], 1'b0} + DVD_W'(den);
  assign dvs      = {1'b0, den} << 1;
  assign nonpos   = num[43] || num == '0;
  assign sat      = dvd >= (DVD_W'(dvs) << 16);

  // Shared divider: level bound first, then one endpoint coordinate at a time.
  logic             div_start, div_busy;
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic [QUO_W-1:0] quo;
  assign div_start = cmd.kdiv_start || (cmd.div_go && !nonpos && !sat);
  assign div_dvd   = cmd.kdiv_start ? DVD_W'(kdvd_s) : dvd;
  assign div_dvs   = cmd.kdiv_start ? DVS_W'(lvl_iv) : dvs;

  msc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur_cell <= in_data;
      mn       <= in_mn;
      mx       <= in_mx;
    end
    if (cmd.kmin_load) begin
      k <= mn[15] ? -18'(quo) : 18'(quo);
    end else if (cmd.lvl_next) begin
      k <= k + 18'sd1;
    end
    if (cmd.t_init) begin
      t <= t_prod[23:0];
    end else if (cmd.lvl_next) begin
      t <= t_next;
    end
    if (cmd.cap) begin
      dropped <= tcap < mx_s;
    end
    if (cmd.case_latch) begin
      case_r <= case_now;
    end
    if (cmd.case_latch) begin
      seg_sel <= 1'b0;
    end else if (cmd.seg_next) begin
      seg_sel <= 1'b1;
    end
    if (cmd.mul1) begin
      p1  <= base * d_mag;
      den <= {10'd0, d_mag} * {15'd0, gwidth - 11'd1};
      n_r <= n_norm;
    end
    if (cmd.mul2) begin
      num <= num_prod[43:0];
    end
    if (cmd.div_go) begin
      pre  <= nonpos ? 16'd0 : 16'hFFFF;
      need <= !nonpos && !sat;
    end
    if (cmd.coord_store) begin
      coord_r[coord_idx] <= need ? quo[15:0] : pre;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      coord_idx <= '0;
    end else begin
      if (cmd.t_init) begin
        cnt <= '0;
      end else if (cmd.lvl_next) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.case_latch || cmd.seg_next) begin
        coord_idx <= '0;
      end else if (cmd.coord_store) begin
        coord_idx <= coord_idx + 2'd1;
      end
    end
  end

  // Edge slot indices.
  logic [11:0] sx_a, sy_a, sx_b, sy_b;
  logic [12:0] stride;
  logic [24:0] slot_a, slot_b;
  logic        seg_pair;
  assign sx_a   = {1'b0, cur_cell.cell_col, 1'b0} + 12'(edge_u(edges.from_edge));
  assign sy_a   = {1'b0, cur_cell.cell_row, 1'b0} + 12'(edge_v(edges.from_edge));
  assign sx_b   = {1'b0, cur_cell.cell_col, 1'b0} + 12'(edge_u(edges.to_edge));
  assign sy_b   = {1'b0, cur_cell.cell_row, 1'b0} + 12'(edge_v(edges.to_edge));
  assign stride = {1'b0, gwidth + 11'd1, 1'b0};
  assign slot_a = 25'(sx_a) + 25'(sy_a * stride);
  assign slot_b = 25'(sx_b) + 25'(sy_b * stride);
  assign seg_pair = case_r == 4'd5 || case_r == 4'd10;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.level_index    <= k[15:0];
      out_data.start_x        <= coord_r[0];
      out_data.start_y        <= coord_r[1];
      out_data.end_x          <= coord_r[2];
      out_data.end_y          <= coord_r[3];
      out_data.start_slot     <= slot_a[22:0];
      out_data.end_slot       <= slot_b[22:0];
      out_data.last_segment   <= !st.seg_more && !next_live;
      out_data.levels_dropped <= dropped;
    end
  end

  always_comb begin
    st.cell_ok    = lvl_iv != '0 && gwidth >= 11'd2 && gwidth <= 11'(MAX_GRID_SIDE) &&
                    cur_cell.cell_col != '0 && cur_cell.cell_row != '0 &&
                    {1'b0, cur_cell.cell_col} < gwidth &&
                    {1'b0, cur_cell.cell_row} < 11'(MAX_GRID_SIDE);
    st.div_busy   = div_busy;
    st.level_live = (t < mx_s) && (cnt < LVL_CNT_W'(MAX_LEVELS));
    st.coord_last = coord_idx == 2'd3;
    st.seg_more   = seg_pair && !seg_sel;
    st.out_free   = !out_valid || !out_stall;
  end

  `MSC_ASSERT_IMPL(a_emit_room, cmd.emit, !(out_valid && out_stall))
  `MSC_ASSERT_NEXT(a_emit_shows, cmd.emit, out_valid)
  `MSC_ASSERT_IMPL(a_div_idle, div_start, !div_busy)
  `MSC_ASSERT_IMPL(a_cnt_cap, cmd.lvl_next, cnt < LVL_CNT_W'(MAX_LEVELS))

endmodule

FILE: sv/msc_ctrl.sv
// ---------------------------------------------------------------------------
// Marching squares cell segments: controller
// Sequences level setup, endpoint arithmetic per segment and result output.
// ---------------------------------------------------------------------------
module msc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  msc_pkg::msc_status_t st,
  output msc_pkg::msc_cmd_t    cmd
);
  import msc_pkg::*;

  msc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_valid) state_next = ST_CHECK;
      ST_CHECK:    state_next = st.cell_ok ? ST_KDIV : ST_IDLE;
      ST_KDIV:     if (!st.div_busy) state_next = ST_LVL_T;
      ST_LVL_T:    state_next = ST_LVL_CAP;
      ST_LVL_CAP:  state_next = ST_LEVEL;
      ST_LEVEL:    state_next = st.level_live ? ST_MUL1 : ST_IDLE;
      ST_MUL1:     state_next = ST_MUL2;
      ST_MUL2:     state_next = ST_DIV_GO;
      ST_DIV_GO:   state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: if (!st.div_busy) state_next = st.coord_last ? ST_EMIT : ST_MUL1;
      ST_EMIT:     if (st.out_free) state_next = st.seg_more ? ST_MUL1 : ST_LEVEL;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      ST_CHECK:    cmd.kdiv_start = st.cell_ok;
      ST_KDIV:     cmd.kmin_load  = !st.div_busy;
      ST_LVL_T:    cmd.t_init     = 1'b1;
      ST_LVL_CAP:  cmd.cap        = 1'b1;
      ST_LEVEL:    cmd.case_latch = st.level_live;
      ST_MUL1:     cmd.mul1       = 1'b1;
      ST_MUL2:     cmd.mul2       = 1'b1;
      ST_DIV_GO:   cmd.div_go     = 1'b1;
      ST_DIV_WAIT: cmd.coord_store = !st.div_busy;
      ST_EMIT: begin
        cmd.emit     = st.out_free;
        cmd.seg_next = st.out_free && st.seg_more;
        cmd.lvl_next = st.out_free && !st.seg_more;
      end
      default: ;
    endcase
  end

endmodule

FILE: sv/marching_squares_cell_segments_top.sv
// ---------------------------------------------------------------------------
// Marching squares cell segments: top level
// Turns one grid cell into its contour segments, one transfer per segment.
// ---------------------------------------------------------------------------
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_stall    cell_in_t, one grid cell
// out      output     out_valid / out_stall  seg_out_t, one contour segment
// cfg      input      cfg_wr_en              cfg_index, cfg_data
//
// After a cell is accepted it runs its setup (one pass through the shared
// 17-step divider for the lowest level), a test of each level, and for each
// segment its four endpoint coordinates: each runs two multiply steps, a
// divider launch and a wait on the same divider; a coordinate that comes out
// zero or saturated skips the divider.
// Reset clears the controller, the output valid and the configuration to
// interval 10, extent 4096, width 256.
// A stall on the output holds the segment in the output register; the
// controller waits in its output state until that register frees up. A new
// cell transfer is taken as soon as the previous cell is finished, even
// while its final segment still waits on the output.
// ---------------------------------------------------------------------------
module marching_squares_cell_segments_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  msc_pkg::cell_in_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output msc_pkg::seg_out_t  out_data,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import msc_pkg::*;

  // Commands from the controller and status back from the datapath.
  msc_cmd_t    cmd;
  msc_status_t st;

  msc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  msc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
